>>> rtl/core/vau_pkg.sv
`timescale 1ns / 1ps

package vau_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        OP_ADDV  = 4'd0,
        OP_ADDS  = 4'd1,
        OP_SUBV  = 4'd2,
        OP_SUBS  = 4'd3,
        OP_MULV  = 4'd4,
        OP_MULS  = 4'd5,
        OP_DIVV  = 4'd6,
        OP_DIVS  = 4'd7,
        OP_DOT   = 4'd8,
        OP_CROSS = 4'd9,
        OP_LEN   = 4'd10,
        OP_NORM  = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef logic [2:0][31:0] vec_t;

    // sideband carried alongside the square root pipeline
    typedef struct packed {
        op_t         op;
        vec_t        r;
        logic [31:0] sc;
        status_t     st;
        vec_t        a;
        vec_t        d;
    } sq_sb_t;

    // sideband carried alongside the divider pipeline
    typedef struct packed {
        op_t         op;
        vec_t        r;
        logic [31:0] sc;
        status_t     st;
        logic [2:0]  a_pos;
        logic [2:0]  a_neg;
        logic [2:0]  dz;
        logic [2:0]  neg;
        logic        len_zero;
    } dv_sb_t;

    function automatic logic signed [65:0] sx66(input logic [63:0] v);
        return {{2{v[63]}}, v};
    endfunction

    // returns {overflow, saturated word}
    function automatic logic [32:0] sat32(input logic [65:0] v);
        if (v[65:31] == '0 || v[65:31] == '1)
        begin
            return {1'b0, v[31:0]};
        end
        return {1'b1, v[65] ? S32_MIN : S32_MAX};
    endfunction

endpackage

>>> rtl/core/vec3_arithmetic_unit.sv
`timescale 1ns / 1ps

// Path: every opcode passes the input stages, the 32-stage square root, the (32 + FRAC_BITS)-stage divider
//   and the output register, so all opcodes take the same path from input word to output word.
// Throughput: one word per clock; the whole pipeline holds while the output word is not taken.
// Reset: rst_n asynchronous, active low; clears every valid bit, data registers keep their contents.

module vec3_arithmetic_unit #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // op[3:0], ax[35:4], ay[67:36], az[99:68], bx[131:100], by[163:132],
    // bz[195:164], scalar_in[227:196], zero pad[231:228]
    input  logic [231:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // rx[31:0], ry[63:32], rz[95:64], scalar_out[127:96], status[129:128],
    // zero pad[135:130]
    output logic [135:0]  m_axis_tdata
);

    import vau_pkg::*;

    localparam int NW = 32 + FRAC_BITS;

    // Global advance: every stage moves when the output register is free or drained.
    logic adv;
    logic m_tvalid_reg;
    logic [135:0] m_tdata_reg;

    assign adv           = !m_tvalid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // Stage 0: unpack the word and steer operands onto the multipliers
    // ---------------------------------------------------------------
    op_t              op_in;
    vec_t             a_in;
    vec_t             b_in;
    logic [31:0]      s_in;
    logic [5:0][31:0] mx_next;
    logic [5:0][31:0] my_next;
    vec_t             e_next;
    vec_t             d_next;

    assign op_in = op_t'(s_axis_tdata[3:0]);
    assign s_in  = s_axis_tdata[227:196];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_in[i] = s_axis_tdata[4 + 32*i +: 32];
            b_in[i] = s_axis_tdata[100 + 32*i +: 32];
        end
        for (int i = 0; i < 3; i++)
        begin
            // cross: lanes 0..2 take the positive terms, lanes 3..5 the negative ones
            if (op_in == OP_CROSS)
            begin
                mx_next[i] = a_in[(i+1)%3];
                my_next[i] = b_in[(i+2)%3];
            end
            else if (op_in == OP_MULS)
            begin
                mx_next[i] = a_in[i];
                my_next[i] = s_in;
            end
            else if (op_in == OP_LEN || op_in == OP_NORM)
            begin
                mx_next[i] = a_in[i];
                my_next[i] = a_in[i];
            end
            else
            begin
                mx_next[i] = a_in[i];
                my_next[i] = b_in[i];
            end
            mx_next[3+i] = a_in[(i+2)%3];
            my_next[3+i] = b_in[(i+1)%3];
            e_next[i] = (op_in == OP_ADDS || op_in == OP_SUBS) ? s_in : b_in[i];
            d_next[i] = (op_in == OP_DIVS) ? s_in : b_in[i];
        end
    end

    logic             v0_reg;
    op_t              op0_reg;
    logic [5:0][31:0] mx0_reg;
    logic [5:0][31:0] my0_reg;
    vec_t             a0_reg;
    vec_t             e0_reg;
    vec_t             d0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op0_reg <= op_in;
            mx0_reg <= mx_next;
            my0_reg <= my_next;
            a0_reg  <= a_in;
            e0_reg  <= e_next;
            d0_reg  <= d_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: six 32x32 signed products, three 33-bit sums
    // ---------------------------------------------------------------
    logic [5:0][63:0] p1_next;
    logic [2:0][32:0] sum1_next;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            p1_next[k] = $signed(mx0_reg[k]) * $signed(my0_reg[k]);
        end
        for (int i = 0; i < 3; i++)
        begin
            if (op0_reg == OP_SUBV || op0_reg == OP_SUBS)
            begin
                sum1_next[i] = $signed({a0_reg[i][31], a0_reg[i]})
                             - $signed({e0_reg[i][31], e0_reg[i]});
            end
            else
            begin
                sum1_next[i] = $signed({a0_reg[i][31], a0_reg[i]})
                             + $signed({e0_reg[i][31], e0_reg[i]});
            end
        end
    end

    logic             v1_reg;
    op_t              op1_reg;
    logic [5:0][63:0] p1_reg;
    logic [2:0][32:0] sum1_reg;
    vec_t             a1_reg;
    vec_t             d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= op0_reg;
            p1_reg   <= p1_next;
            sum1_reg <= sum1_next;
            a1_reg   <= a0_reg;
            d1_reg   <= d0_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: truncate products toward zero, combine, saturate.
    // Sum of squares goes on to the square root.
    // ---------------------------------------------------------------
    logic [5:0][63:0] t2;
    logic [63:0]      rad2;
    sq_sb_t           sb2;

    always_comb
    begin
        logic [2:0] ovf;
        for (int k = 0; k < 6; k++)
        begin
            t2[k] = 64'($signed(p1_reg[k]) >>> FRAC_BITS)
                  + {63'd0, p1_reg[k][63] && (p1_reg[k][FRAC_BITS-1:0] != '0)};
        end
        rad2   = p1_reg[0] + p1_reg[1] + p1_reg[2];
        ovf    = '0;
        sb2    = '0;
        sb2.op = op1_reg;
        sb2.a  = a1_reg;
        sb2.d  = d1_reg;
        case (op1_reg)
            OP_ADDV, OP_ADDS, OP_SUBV, OP_SUBS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    {ovf[i], sb2.r[i]} = sat32({{33{sum1_reg[i][32]}}, sum1_reg[i]});
                end
            end
            OP_MULV, OP_MULS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    {ovf[i], sb2.r[i]} = sat32(sx66(t2[i]));
                end
            end
            OP_DOT:
            begin
                {ovf[0], sb2.sc} = sat32(sx66(t2[0]) + sx66(t2[1]) + sx66(t2[2]));
            end
            OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    {ovf[i], sb2.r[i]} = sat32(sx66(t2[i]) - sx66(t2[3+i]));
                end
            end
            default:
            begin
            end
        endcase
        sb2.st = (ovf != '0) ? ST_SAT : ST_OK;
    end

    // ---------------------------------------------------------------
    // Square root: every word passes through, only len and norm use it
    // ---------------------------------------------------------------
    logic                 v_sq;
    logic [31:0]          len_sq;
    logic [$bits(sq_sb_t)-1:0] sb_sq_raw;
    sq_sb_t               sb_sq;

    vau_sqrt #(
        .SB_W($bits(sq_sb_t))
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (v1_reg),
        .rad      (rad2),
        .sb_in    (sb2),
        .out_valid(v_sq),
        .root     (len_sq),
        .sb_out   (sb_sq_raw)
    );

    assign sb_sq = sb_sq_raw;

    // ---------------------------------------------------------------
    // Divider set-up: magnitudes, signs and the zero-divisor flags.
    // Norm divides by the unsaturated length.
    // ---------------------------------------------------------------
    logic [2:0][NW-1:0] num_di;
    logic [2:0][31:0]   den_di;
    dv_sb_t             sb_di;

    always_comb
    begin
        logic        is_norm;
        logic [31:0] amag;
        logic [31:0] dmag;
        is_norm      = (sb_sq.op == OP_NORM);
        sb_di.op     = sb_sq.op;
        sb_di.r      = sb_sq.r;
        sb_di.sc     = sb_sq.sc;
        sb_di.st     = sb_sq.st;
        sb_di.len_zero = (len_sq == '0);
        if (sb_sq.op == OP_LEN)
        begin
            sb_di.sc = len_sq[31] ? S32_MAX : len_sq;
            sb_di.st = len_sq[31] ? ST_SAT : ST_OK;
        end
        for (int i = 0; i < 3; i++)
        begin
            amag = sb_sq.a[i][31] ? 32'(-sb_sq.a[i]) : sb_sq.a[i];
            dmag = sb_sq.d[i][31] ? 32'(-sb_sq.d[i]) : sb_sq.d[i];
            num_di[i] = {amag, {FRAC_BITS{1'b0}}};
            den_di[i] = is_norm ? len_sq : dmag;
            sb_di.neg[i]   = is_norm ? sb_sq.a[i][31] : (sb_sq.a[i][31] ^ sb_sq.d[i][31]);
            sb_di.dz[i]    = !is_norm && (sb_sq.d[i] == '0);
            sb_di.a_neg[i] = sb_sq.a[i][31];
            sb_di.a_pos[i] = !sb_sq.a[i][31] && (sb_sq.a[i] != '0);
        end
    end

    logic                      v_dv;
    logic [2:0][NW-1:0]        quo_dv;
    logic [$bits(dv_sb_t)-1:0] sb_dv_raw;
    dv_sb_t                    sb_dv;

    vau_div #(
        .FRAC_BITS(FRAC_BITS),
        .SB_W     ($bits(dv_sb_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (v_sq),
        .num      (num_di),
        .den      (den_di),
        .sb_in    (sb_di),
        .out_valid(v_dv),
        .quo      (quo_dv),
        .sb_out   (sb_dv_raw)
    );

    assign sb_dv = sb_dv_raw;

    // ---------------------------------------------------------------
    // Final: restore quotient sign, saturate, settle the status
    // ---------------------------------------------------------------
    vec_t        r_fin;
    logic [31:0] sc_fin;
    status_t     st_fin;

    always_comb
    begin
        logic [NW-1:0] q;
        logic          qs;
        logic [2:0]    sat;
        r_fin  = sb_dv.r;
        sc_fin = sb_dv.sc;
        st_fin = sb_dv.st;
        sat    = '0;
        q      = '0;
        qs     = 1'b0;
        if (sb_dv.op == OP_DIVV || sb_dv.op == OP_DIVS || sb_dv.op == OP_NORM)
        begin
            for (int l = 0; l < 3; l++)
            begin
                q = quo_dv[l];
                if (sb_dv.neg[l])
                begin
                    qs = (q[NW-1:32] != '0) || (q[31] && (q[30:0] != '0));
                end
                else
                begin
                    qs = (q[NW-1:31] != '0);
                end
                if (sb_dv.dz[l])
                begin
                    r_fin[l] = sb_dv.a_pos[l] ? S32_MAX : (sb_dv.a_neg[l] ? S32_MIN : '0);
                end
                else if (qs)
                begin
                    r_fin[l] = sb_dv.neg[l] ? S32_MIN : S32_MAX;
                    sat[l]   = 1'b1;
                end
                else
                begin
                    r_fin[l] = sb_dv.neg[l] ? 32'(32'd0 - q[31:0]) : q[31:0];
                end
            end
            // a zero vector has no direction: clear it and flag
            if (sb_dv.op == OP_NORM && sb_dv.len_zero)
            begin
                r_fin  = '0;
                st_fin = ST_DIVZ;
            end
            else if (sb_dv.dz != '0)
            begin
                st_fin = ST_DIVZ;
            end
            else if (sat != '0)
            begin
                st_fin = ST_SAT;
            end
            else
            begin
                st_fin = ST_OK;
            end
        end
    end

    // Output register: hold the word until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= v_dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata_reg <= {6'd0, st_fin, sc_fin, r_fin[2], r_fin[1], r_fin[0]};
        end
    end

endmodule

>>> rtl/core/vau_sqrt.sv
`timescale 1ns / 1ps

module vau_sqrt #(
    parameter int SB_W = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [63:0]     rad,
    input  logic [SB_W-1:0] sb_in,
    output logic            out_valid,
    output logic [31:0]     root,
    output logic [SB_W-1:0] sb_out
);

    logic [32:0]     vld_reg;
    logic [63:0]     rad_reg  [33];
    logic [31:0]     rem_reg  [33];
    logic [31:0]     root_reg [33];
    logic [SB_W-1:0] sb_reg   [33];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            sb_reg[0]   <= sb_in;
        end
    end

    // one root bit per stage: bring down two radicand bits, try 4r+1
    for (genvar j = 0; j < 32; j++)
    begin : g_step
        logic [31:0] rem_next;
        logic [31:0] root_next;

        always_comb
        begin
            logic [33:0] rs;
            logic [33:0] trial;
            rs    = {rem_reg[j], rad_reg[j][63:62]};
            trial = {root_reg[j], 2'b01};
            if (rs >= trial)
            begin
                rem_next  = 32'(rs - trial);
                root_next = {root_reg[j][30:0], 1'b1};
            end
            else
            begin
                rem_next  = rs[31:0];
                root_next = {root_reg[j][30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[j+1]  <= {rad_reg[j][61:0], 2'b00};
                rem_reg[j+1]  <= rem_next;
                root_reg[j+1] <= root_next;
                sb_reg[j+1]   <= sb_reg[j];
            end
        end
    end

    assign out_valid = vld_reg[32];
    assign root      = root_reg[32];
    assign sb_out    = sb_reg[32];

endmodule

>>> rtl/core/vau_div.sv
`timescale 1ns / 1ps

module vau_div #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF,
    parameter int SB_W      = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [2:0][32+FRAC_BITS-1:0]  num,
    input  logic [2:0][31:0]              den,
    input  logic [SB_W-1:0]               sb_in,
    output logic                          out_valid,
    output logic [2:0][32+FRAC_BITS-1:0]  quo,
    output logic [SB_W-1:0]               sb_out
);

    localparam int NW = 32 + FRAC_BITS;

    logic [NW:0]             vld_reg;
    logic [2:0][NW-1:0]      num_reg [NW+1];
    logic [2:0][31:0]        rem_reg [NW+1];
    logic [2:0][31:0]        den_reg [NW+1];
    logic [SB_W-1:0]         sb_reg  [NW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= num;
            rem_reg[0] <= '0;
            den_reg[0] <= den;
            sb_reg[0]  <= sb_in;
        end
    end

    // one quotient bit per stage per lane; quotient bits shift in behind the dividend
    for (genvar k = 0; k < NW; k++)
    begin : g_step
        logic [2:0][NW-1:0] num_next;
        logic [2:0][31:0]   rem_next;

        always_comb
        begin
            logic [32:0] rs;
            for (int l = 0; l < 3; l++)
            begin
                rs = {rem_reg[k][l], num_reg[k][l][NW-1]};
                if (rs >= {1'b0, den_reg[k][l]})
                begin
                    rem_next[l] = 32'(rs - {1'b0, den_reg[k][l]});
                    num_next[l] = {num_reg[k][l][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = rs[31:0];
                    num_next[l] = {num_reg[k][l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k+1] <= num_next;
                rem_reg[k+1] <= rem_next;
                den_reg[k+1] <= den_reg[k];
                sb_reg[k+1]  <= sb_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[NW];
    assign quo       = num_reg[NW];
    assign sb_out    = sb_reg[NW];

endmodule

>>> bench/vec3_arithmetic_unit_tb.sv
`timescale 1ns / 1ps

module vec3_arithmetic_unit_tb;

    import vau_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = 37 + 32 + FB;

    localparam logic signed [63:0] WMAX = 64'sd2147483647;
    localparam logic signed [63:0] WMIN = -64'sd2147483648;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] ax, ay, az, bx, by, bz, sc;
    } vop_t;

    typedef struct packed {
        logic [31:0] rx, ry, rz, sc;
        logic [1:0]  st;
    } vres_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // op, ax, ay, az, bx, by, bz, scalar_in, zero pad (lowest bit up)
    logic [231:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // rx, ry, rz, scalar_out, status, zero pad (lowest bit up)
    logic [135:0] m_axis_tdata;

    vres_t result_q[$];
    int    fail_cnt;
    bit    calm;
    int    stall_cnt;

    vec3_arithmetic_unit #(.FRAC_BITS(FB)) dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    // saturate to a word, record overflow without overriding a divide-by-zero
    function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic [1:0] st);
        if (v > WMAX)
        begin
            if (st == ST_OK) st = ST_SAT;
            return WMAX[31:0];
        end
        if (v < WMIN)
        begin
            if (st == ST_OK) st = ST_SAT;
            return WMIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] qmul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return p / (128'sd1 <<< FB);
    endfunction

    function automatic logic [31:0] qdiv(input logic signed [63:0] a,
                                         input logic signed [63:0] d, inout logic [1:0] st);
        logic signed [127:0] q;
        if (d == 0)
        begin
            st = ST_DIVZ;
            return a > 0 ? WMAX[31:0] : (a < 0 ? WMIN[31:0] : 32'd0);
        end
        q = (128'(a) <<< FB) / 128'(d);
        return clamp(q, st);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic vres_t compute_vector(input vop_t v);
        vres_t               o;
        logic signed [63:0]  a[3], b[3], s;
        logic [1:0]          st;
        logic [63:0]         sum, len;
        o = '0;
        st = ST_OK;
        a[0] = 64'(signed'(v.ax)); a[1] = 64'(signed'(v.ay)); a[2] = 64'(signed'(v.az));
        b[0] = 64'(signed'(v.bx)); b[1] = 64'(signed'(v.by)); b[2] = 64'(signed'(v.bz));
        s = 64'(signed'(v.sc));
        case (v.op)
            OP_ADDV: begin o.rx = clamp(a[0] + b[0], st); o.ry = clamp(a[1] + b[1], st);
                           o.rz = clamp(a[2] + b[2], st); end
            OP_ADDS: begin o.rx = clamp(a[0] + s, st); o.ry = clamp(a[1] + s, st);
                           o.rz = clamp(a[2] + s, st); end
            OP_SUBV: begin o.rx = clamp(a[0] - b[0], st); o.ry = clamp(a[1] - b[1], st);
                           o.rz = clamp(a[2] - b[2], st); end
            OP_SUBS: begin o.rx = clamp(a[0] - s, st); o.ry = clamp(a[1] - s, st);
                           o.rz = clamp(a[2] - s, st); end
            OP_MULV: begin o.rx = clamp(qmul(a[0], b[0]), st); o.ry = clamp(qmul(a[1], b[1]), st);
                           o.rz = clamp(qmul(a[2], b[2]), st); end
            OP_MULS: begin o.rx = clamp(qmul(a[0], s), st); o.ry = clamp(qmul(a[1], s), st);
                           o.rz = clamp(qmul(a[2], s), st); end
            OP_DIVV: begin o.rx = qdiv(a[0], b[0], st); o.ry = qdiv(a[1], b[1], st);
                           o.rz = qdiv(a[2], b[2], st); end
            OP_DIVS: begin o.rx = qdiv(a[0], s, st); o.ry = qdiv(a[1], s, st);
                           o.rz = qdiv(a[2], s, st); end
            OP_DOT:
                o.sc = clamp(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]), st);
            OP_CROSS:
            begin
                o.rx = clamp(qmul(a[1], b[2]) - qmul(a[2], b[1]), st);
                o.ry = clamp(qmul(a[2], b[0]) - qmul(a[0], b[2]), st);
                o.rz = clamp(qmul(a[0], b[1]) - qmul(a[1], b[0]), st);
            end
            OP_LEN, OP_NORM:
            begin
                // squares sum modulo 2^64, as the word-wide accumulator does
                sum = 64'(a[0] * a[0]) + 64'(a[1] * a[1]) + 64'(a[2] * a[2]);
                len = root64(sum);
                if (v.op == OP_LEN)
                    o.sc = clamp(128'(len), st);
                else if (len == 0)
                    st = ST_DIVZ;
                else
                begin
                    o.rx = qdiv(a[0], signed'(len), st);
                    o.ry = qdiv(a[1], signed'(len), st);
                    o.rz = qdiv(a[2], signed'(len), st);
                end
            end
            default: ;
        endcase
        o.st = st;
        return o;
    endfunction

    // push one word into the block, with an optional idle burst first;
    // tvalid stays up afterwards until the next word or a drain drops it
    task automatic send_word(input vop_t v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, v.sc, v.bz, v.by, v.bx, v.az, v.ay, v.ax, v.op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        result_q.push_back(compute_vector(v));
        @(negedge clk);
    endtask

    // receiver backpressure in random bursts, off in the quiet tail
    always @(negedge clk)
    begin
        if (!rst_n || calm)
        begin
            m_axis_tready <= 1'b1;
            stall_cnt = 0;
        end
        else if (stall_cnt > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt--;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt = $urandom_range(0, 2);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        vres_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[129:0];
            got = '{rx: m_axis_tdata[31:0], ry: m_axis_tdata[63:32], rz: m_axis_tdata[95:64],
                    sc: m_axis_tdata[127:96], st: m_axis_tdata[129:128]};
            if (result_q.size() == 0)
            begin
                $error("unexpected result word");
                fail_cnt++;
            end
            else
            begin
                want = result_q.pop_front();
                if (got.rx !== want.rx)
                begin $error("rx expected %h actual %h", want.rx, got.rx); fail_cnt++; end
                if (got.ry !== want.ry)
                begin $error("ry expected %h actual %h", want.ry, got.ry); fail_cnt++; end
                if (got.rz !== want.rz)
                begin $error("rz expected %h actual %h", want.rz, got.rz); fail_cnt++; end
                if (got.sc !== want.sc)
                begin $error("scalar_out expected %h actual %h", want.sc, got.sc); fail_cnt++; end
                if (got.st !== want.st)
                begin $error("status expected %0d actual %0d", want.st, got.st); fail_cnt++; end
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return 32'(signed'($urandom_range(0, 8'hff)) - 128);
            4: return 32'(signed'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic vop_t random_vector(input logic [3:0] op);
        vop_t v;
        v.op = op;
        v.ax = pick_word(); v.ay = pick_word(); v.az = pick_word();
        v.bx = pick_word(); v.by = pick_word(); v.bz = pick_word();
        v.sc = pick_word();
        return v;
    endfunction

    // drop tvalid and wait for every outstanding result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // extremes, every opcode, zero divisors, zero-vector normalise, unused codes
    task automatic test_directed();
        vop_t v;
        for (int k = 0; k < 16; k++)
        begin
            v = '{op: k[3:0], ax: 32'h7fff_ffff, ay: 32'h8000_0000, az: 32'h0001_0000,
                  bx: 32'h7fff_ffff, by: 32'h0000_0000, bz: 32'hffff_0000, sc: 32'h8000_0000};
            send_word(v);
        end
        send_word('{op: OP_DIVS, ax: 32'h10000, ay: 32'hffff_0000, az: 0,
                    bx: 0, by: 0, bz: 0, sc: 0});
        send_word('{op: OP_NORM, ax: 0, ay: 0, az: 0, bx: '1, by: '1, bz: '1, sc: '1});
        send_word('{op: OP_NORM, ax: 32'h30000, ay: 32'h40000, az: 0, bx: 0, by: 0, bz: 0,
                    sc: 0});
        send_word('{op: OP_LEN, ax: 32'h8000_0000, ay: 32'h8000_0000, az: 32'h8000_0000,
                    bx: 0, by: 0, bz: 0, sc: 0});
        send_word('{op: OP_DIVV, ax: 32'h7fff_ffff, ay: 1, az: 32'h8000_0000,
                    bx: 1, by: 0, bz: 32'hffff_ffff, sc: 0});
        send_word('{op: OP_DOT, ax: '1, ay: '1, az: '1, bx: '1, by: '1, bz: '1, sc: '1});
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++)
            send_word(random_vector(4'($urandom_range(0, 15))));
    endtask

    // every result must arrive before more words are sent
    task automatic test_pause();
        drain();
        test_random(50);
        drain();
    endtask

    task automatic test_calm(input int n);
        calm = 1'b1;
        test_random(n);
    endtask

    initial
    begin
        fail_cnt      = 0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(1200);
        test_pause();
        test_random(300);
        test_calm(250);
        drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_cnt == 0 && result_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
